>>> rtl/lhp_pkg.sv
// Shared types, constants and the bucket limit table of the latency histogram.
// No dependencies; used by every module of the block.
`default_nettype none

package lhp_pkg;

    localparam int NUM_BUCKETS   = 154;
    localparam int COUNT_WIDTH   = 32;
    localparam int SAMPLE_WIDTH  = 40;
    localparam int FINITE_LIMITS = 153;
    localparam int BIDX_W        = $clog2(NUM_BUCKETS);
    localparam int LIMIT_W       = 34;
    localparam int PCT_W         = 14;
    localparam int TGT_W         = COUNT_WIDTH + PCT_W;
    localparam int REM_W         = TGT_W + 2;
    localparam int SPAN_W        = LIMIT_W + 8;
    localparam int VALUE_W       = 48;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [PCT_W-1:0] PCT_SCALE = 14'd10000;
    localparam logic [PCT_W-1:0] PCT_RESET = 14'd9900;
    localparam logic [BIDX_W-1:0] LAST_BUCKET = BIDX_W'(NUM_BUCKETS - 1);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    localparam logic REG_PCT = 1'b0;

    localparam logic [LIMIT_W-1:0] LIMIT_TAB [0:FINITE_LIMITS-1] = '{
        34'd1, 34'd2, 34'd3, 34'd4, 34'd5, 34'd6, 34'd7, 34'd8, 34'd9, 34'd10,
        34'd12, 34'd14, 34'd16, 34'd18, 34'd20, 34'd25, 34'd30, 34'd35, 34'd40,
        34'd45, 34'd50, 34'd60, 34'd70, 34'd80, 34'd90, 34'd100, 34'd120,
        34'd140, 34'd160, 34'd180, 34'd200, 34'd250, 34'd300, 34'd350, 34'd400,
        34'd450, 34'd500, 34'd600, 34'd700, 34'd800, 34'd900, 34'd1000,
        34'd1200, 34'd1400, 34'd1600, 34'd1800, 34'd2000, 34'd2500, 34'd3000,
        34'd3500, 34'd4000, 34'd4500, 34'd5000, 34'd6000, 34'd7000, 34'd8000,
        34'd9000, 34'd10000, 34'd12000, 34'd14000, 34'd16000, 34'd18000,
        34'd20000, 34'd25000, 34'd30000, 34'd35000, 34'd40000, 34'd45000,
        34'd50000, 34'd60000, 34'd70000, 34'd80000, 34'd90000, 34'd100000,
        34'd120000, 34'd140000, 34'd160000, 34'd180000, 34'd200000,
        34'd250000, 34'd300000, 34'd350000, 34'd400000, 34'd450000,
        34'd500000, 34'd600000, 34'd700000, 34'd800000, 34'd900000,
        34'd1000000, 34'd1200000, 34'd1400000, 34'd1600000, 34'd1800000,
        34'd2000000, 34'd2500000, 34'd3000000, 34'd3500000, 34'd4000000,
        34'd4500000, 34'd5000000, 34'd6000000, 34'd7000000, 34'd8000000,
        34'd9000000, 34'd10000000, 34'd12000000, 34'd14000000, 34'd16000000,
        34'd18000000, 34'd20000000, 34'd25000000, 34'd30000000, 34'd35000000,
        34'd40000000, 34'd45000000, 34'd50000000, 34'd60000000, 34'd70000000,
        34'd80000000, 34'd90000000, 34'd100000000, 34'd120000000,
        34'd140000000, 34'd160000000, 34'd180000000, 34'd200000000,
        34'd250000000, 34'd300000000, 34'd350000000, 34'd400000000,
        34'd450000000, 34'd500000000, 34'd600000000, 34'd700000000,
        34'd800000000, 34'd900000000, 34'd1000000000, 34'd1200000000,
        34'd1400000000, 34'd1600000000, 34'd1800000000, 34'd2000000000,
        34'd2500000000, 34'd3000000000, 34'd3500000000, 34'd4000000000,
        34'd4500000000, 34'd5000000000, 34'd6000000000, 34'd7000000000,
        34'd8000000000, 34'd9000000000
    };

    typedef struct packed {
        logic [1:0]              mode;
        logic [SAMPLE_WIDTH-1:0] sample;
    } lhp_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0]      percentile_value;
        logic [SAMPLE_WIDTH-1:0] min_seen;
        logic [SAMPLE_WIDTH-1:0] max_seen;
        logic [COUNT_WIDTH-1:0]  sample_count;
        logic                    empty_res;
    } lhp_out_t;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic [TGT_W-1:0]  numer;
        logic [TGT_W-1:0]  denom;
    } lhp_md_req_t;

    // buckets past the table reuse the last finite limit
    function automatic logic [LIMIT_W-1:0] limit_of(input logic [BIDX_W-1:0] b);
        logic [LIMIT_W-1:0] lim;
        if (b < BIDX_W'(FINITE_LIMITS))
            lim = LIMIT_TAB[b];
        else
            lim = LIMIT_TAB[FINITE_LIMITS-1];
        return lim;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lhp_bucket_store.sv
// Bucket count memory: one write and one registered read port, per-entry valid bits.
// Depends on lhp_pkg.
`default_nettype none

module lhp_bucket_store (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               clr,
    input  wire logic                               rd_en,
    input  wire logic [lhp_pkg::BIDX_W-1:0]         rd_addr,
    output logic      [lhp_pkg::COUNT_WIDTH-1:0]    rd_data,
    input  wire logic                               wr_en,
    input  wire logic [lhp_pkg::BIDX_W-1:0]         wr_addr,
    input  wire logic [lhp_pkg::COUNT_WIDTH-1:0]    wr_data
);

    logic [lhp_pkg::COUNT_WIDTH-1:0] mem [0:lhp_pkg::NUM_BUCKETS-1];
    logic [lhp_pkg::NUM_BUCKETS-1:0] valid_reg;
    logic [lhp_pkg::COUNT_WIDTH-1:0] rd_data_reg;
    logic                            rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_vld_reg <= valid_reg[rd_addr];
            if (clr)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/lhp_bucket_search.sv
// Binary search of the limit table: one index bit per cycle.
// Depends on lhp_pkg.
`default_nettype none

module lhp_bucket_search (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [lhp_pkg::SAMPLE_WIDTH-1:0]   sample,
    output logic                                    done,
    output logic      [lhp_pkg::BIDX_W-1:0]         bidx
);

    localparam int K_W = $clog2(lhp_pkg::BIDX_W);

    logic                              busy_reg;
    logic                              done_reg;
    logic [K_W-1:0]                    k_reg;
    logic [lhp_pkg::BIDX_W-1:0]        pos_reg;
    logic [lhp_pkg::SAMPLE_WIDTH-1:0]  sample_reg;
    logic [lhp_pkg::BIDX_W-1:0]        trial;
    logic [lhp_pkg::BIDX_W-1:0]        cand;
    logic                              take;

    always_comb
    begin
        trial = pos_reg | (lhp_pkg::BIDX_W'(1) << k_reg);
        cand  = trial - lhp_pkg::BIDX_W'(1);
        take  = (cand < lhp_pkg::BIDX_W'(lhp_pkg::FINITE_LIMITS)) &&
                (lhp_pkg::SAMPLE_WIDTH'(lhp_pkg::limit_of(cand)) <= sample_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= K_W'(lhp_pkg::BIDX_W - 1);
                pos_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (take)
                    pos_reg <= trial;
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    k_reg <= k_reg - K_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            sample_reg <= sample;
    end

    assign done = done_reg;
    assign bidx = pos_reg;

endmodule

`default_nettype wire

>>> rtl/lhp_muldiv.sv
// Serial floor(span * numer / denom), one span bit per cycle; needs numer <= denom.
// Depends on lhp_pkg.
`default_nettype none

module lhp_muldiv (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire lhp_pkg::lhp_md_req_t         req,
    output logic                              done,
    output logic      [lhp_pkg::SPAN_W-1:0]   quot
);

    localparam int CNT_W = $clog2(lhp_pkg::SPAN_W + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [lhp_pkg::SPAN_W-1:0]   span_reg;
    logic [lhp_pkg::TGT_W-1:0]    numer_reg;
    logic [lhp_pkg::REM_W-1:0]    denom1_reg;
    logic [lhp_pkg::REM_W-1:0]    rem_reg;
    logic [lhp_pkg::SPAN_W-1:0]   q_reg;
    logic [lhp_pkg::REM_W-1:0]    t;
    logic [lhp_pkg::REM_W-1:0]    d2;
    logic [lhp_pkg::REM_W-1:0]    rem_next;
    logic [1:0]                   qd;

    // remainder stays below denom, so t < 3*denom and the digit is 0..2
    always_comb
    begin
        d2 = denom1_reg << 1;
        t  = (rem_reg << 1) +
             (span_reg[lhp_pkg::SPAN_W-1] ? lhp_pkg::REM_W'(numer_reg) : '0);
        if (t >= d2)
        begin
            rem_next = t - d2;
            qd       = 2'd2;
        end
        else if (t >= denom1_reg)
        begin
            rem_next = t - denom1_reg;
            qd       = 2'd1;
        end
        else
        begin
            rem_next = t;
            qd       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(lhp_pkg::SPAN_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            span_reg   <= req.span;
            numer_reg  <= req.numer;
            denom1_reg <= lhp_pkg::REM_W'(req.denom);
            rem_reg    <= '0;
            q_reg      <= '0;
        end
        else if (busy_reg)
        begin
            span_reg <= span_reg << 1;
            rem_reg  <= rem_next;
            q_reg    <= (q_reg << 1) + lhp_pkg::SPAN_W'(qd);
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

>>> rtl/latency_histogram_percentile.sv
// Latency histogram with percentile report: top level, control sequencer and APB register.
// Depends on lhp_pkg, lhp_bucket_store, lhp_bucket_search, lhp_muldiv.
//
// Input channel req (req_valid/req_stall): mode add counts a sample into one of
// 154 log-spaced buckets and tracks min/max/count; clear empties the histogram;
// report yields one item on rsp (rsp_valid/rsp_stall); mode 3 is dropped.
// One item is worked on at a time; req_stall is low only while idle.
//   add    : 8-step limit-table search, bucket read, write-back
//   clear  : valid bits of the bucket memory drop at once
//   report : per bucket a read, accumulate, scale and check, up to the matching one
//            (at most 154), then the serial interpolation divide if needed, clamp and output.
// The bucket scan walks the single read port of the count memory.
// The result sits in an output register; a new item is taken while it waits,
// and a later report holds in its last state until that register frees up.
// A stalled rsp item holds its payload.
// Reset empties the histogram (min all ones, max and count zero) and sets the
// percentile register (APB address 0, 14 bits, hundredths of a percent) to 99.00.
// Write the register only while the block is idle.
`default_nettype none

module latency_histogram_percentile (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire lhp_pkg::lhp_in_t              req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output lhp_pkg::lhp_out_t                  rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lhp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lhp_pkg::PDATA_W-1:0]   pwdata,
    output logic      [lhp_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SRCH,
        S_ADD_RD,
        S_ADD_WR,
        S_RPT_RD,
        S_RPT_ACC,
        S_RPT_MUL,
        S_RPT_CHK,
        S_RPT_HIT,
        S_RPT_DIV,
        S_CLAMP,
        S_OUT
    } state_t;

    localparam logic [lhp_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    state_t                                state_reg;
    logic [lhp_pkg::PCT_W-1:0]             pct_reg;
    logic [lhp_pkg::SAMPLE_WIDTH-1:0]      min_reg;
    logic [lhp_pkg::SAMPLE_WIDTH-1:0]      max_reg;
    logic [lhp_pkg::COUNT_WIDTH-1:0]       total_reg;
    logic [lhp_pkg::SAMPLE_WIDTH-1:0]      sample_reg;
    logic [lhp_pkg::BIDX_W-1:0]            idx_reg;
    logic [lhp_pkg::COUNT_WIDTH-1:0]       sum_reg;
    logic [lhp_pkg::TGT_W-1:0]             tgt_reg;
    logic [lhp_pkg::TGT_W-1:0]             prod_reg;
    logic [lhp_pkg::TGT_W-1:0]             lprod_reg;
    logic [lhp_pkg::TGT_W-1:0]             numer_reg;
    logic [lhp_pkg::TGT_W-1:0]             denom_reg;
    logic [lhp_pkg::VALUE_W-1:0]           r_reg;
    logic                                  empty_reg;
    logic                                  rsp_valid_reg;
    lhp_pkg::lhp_out_t                     rsp_reg;

    logic                                  accept;
    logic                                  cfg_wr;
    logic                                  out_free;
    logic                                  srch_start;
    logic                                  srch_done;
    logic [lhp_pkg::BIDX_W-1:0]            srch_bidx;
    logic                                  st_rd_en;
    logic [lhp_pkg::BIDX_W-1:0]            st_rd_addr;
    logic [lhp_pkg::COUNT_WIDTH-1:0]       st_rd_data;
    logic                                  st_wr_en;
    logic [lhp_pkg::COUNT_WIDTH-1:0]       st_wr_data;
    logic                                  st_clr;
    logic                                  md_start;
    lhp_pkg::lhp_md_req_t                  md_req;
    logic                                  md_done;
    logic [lhp_pkg::SPAN_W-1:0]            md_quot;
    logic [lhp_pkg::LIMIT_W-1:0]           left_lim;
    logic [lhp_pkg::COUNT_WIDTH:0]         sum_wide;
    logic [lhp_pkg::VALUE_W-1:0]           min_fx;
    logic [lhp_pkg::VALUE_W-1:0]           max_fx;
    logic [lhp_pkg::VALUE_W-1:0]           r_lo;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == lhp_pkg::REG_PCT) ?
                       lhp_pkg::PDATA_W'(pct_reg) : '0;

    assign srch_start = accept && (req.mode == lhp_pkg::MODE_ADD);
    assign st_clr     = accept && (req.mode == lhp_pkg::MODE_CLEAR);
    assign st_rd_en   = (state_reg == S_ADD_RD) || (state_reg == S_RPT_RD);
    assign st_rd_addr = (state_reg == S_ADD_RD) ? srch_bidx : idx_reg;
    assign st_wr_en   = (state_reg == S_ADD_WR);
    assign st_wr_data = (st_rd_data == COUNT_MAX) ? st_rd_data
                                                  : st_rd_data + lhp_pkg::COUNT_WIDTH'(1);

    // saturating running sum of the scan
    assign sum_wide = {1'b0, sum_reg} + {1'b0, st_rd_data};

    assign left_lim = (idx_reg == '0) ? '0
                      : lhp_pkg::limit_of(idx_reg - lhp_pkg::BIDX_W'(1));
    assign min_fx   = {min_reg, 8'b0};
    assign max_fx   = {max_reg, 8'b0};
    assign r_lo     = (r_reg < min_fx) ? min_fx : r_reg;

    assign md_start     = (state_reg == S_RPT_HIT) && (denom_reg != '0) &&
                          (numer_reg != '0) && (idx_reg != lhp_pkg::LAST_BUCKET);
    assign md_req.span  = (lhp_pkg::SPAN_W'(lhp_pkg::limit_of(idx_reg)) -
                           lhp_pkg::SPAN_W'(left_lim)) << 8;
    assign md_req.numer = numer_reg;
    assign md_req.denom = denom_reg;

    lhp_bucket_search u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (srch_start),
        .sample (req.sample),
        .done   (srch_done),
        .bidx   (srch_bidx)
    );

    lhp_bucket_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (st_clr),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (srch_bidx),
        .wr_data (st_wr_data)
    );

    lhp_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .req   (md_req),
        .done  (md_done),
        .quot  (md_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pct_reg       <= lhp_pkg::PCT_RESET;
            min_reg       <= '1;
            max_reg       <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == lhp_pkg::REG_PCT))
                pct_reg <= pwdata[lhp_pkg::PCT_W-1:0];
            // drop valid on delivery unless a new report loads in the same cycle
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_OUT))
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.mode)
                            lhp_pkg::MODE_ADD:
                                state_reg <= S_ADD_SRCH;
                            lhp_pkg::MODE_CLEAR:
                            begin
                                min_reg   <= '1;
                                max_reg   <= '0;
                                total_reg <= '0;
                            end
                            lhp_pkg::MODE_REPORT:
                                state_reg <= (total_reg == '0) ? S_OUT : S_RPT_RD;
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_ADD_SRCH:
                    if (srch_done)
                        state_reg <= S_ADD_RD;
                S_ADD_RD:
                    state_reg <= S_ADD_WR;
                S_ADD_WR:
                begin
                    if (sample_reg < min_reg)
                        min_reg <= sample_reg;
                    if (sample_reg > max_reg)
                        max_reg <= sample_reg;
                    if (total_reg != COUNT_MAX)
                        total_reg <= total_reg + lhp_pkg::COUNT_WIDTH'(1);
                    state_reg <= S_IDLE;
                end
                S_RPT_RD:
                    state_reg <= S_RPT_ACC;
                S_RPT_ACC:
                    state_reg <= S_RPT_MUL;
                S_RPT_MUL:
                    state_reg <= S_RPT_CHK;
                S_RPT_CHK:
                begin
                    if (prod_reg >= tgt_reg)
                        state_reg <= S_RPT_HIT;
                    else if (idx_reg == lhp_pkg::LAST_BUCKET)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_RPT_RD;
                end
                S_RPT_HIT:
                    state_reg <= md_start ? S_RPT_DIV : S_CLAMP;
                S_RPT_DIV:
                    if (md_done)
                        state_reg <= S_CLAMP;
                S_CLAMP:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        rsp_valid_reg <= 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge clk)
    begin
        if (srch_start)
            sample_reg <= req.sample;
        if (accept && (req.mode == lhp_pkg::MODE_REPORT))
        begin
            tgt_reg   <= lhp_pkg::TGT_W'(total_reg) * lhp_pkg::TGT_W'(pct_reg);
            idx_reg   <= '0;
            sum_reg   <= '0;
            prod_reg  <= '0;
            lprod_reg <= '0;
            r_reg     <= '0;
            empty_reg <= (total_reg == '0);
        end
        case (state_reg)
            S_RPT_ACC:
                sum_reg <= sum_wide[lhp_pkg::COUNT_WIDTH] ? COUNT_MAX
                                                          : sum_wide[lhp_pkg::COUNT_WIDTH-1:0];
            S_RPT_MUL:
            begin
                prod_reg  <= lhp_pkg::TGT_W'(sum_reg) * lhp_pkg::TGT_W'(lhp_pkg::PCT_SCALE);
                lprod_reg <= prod_reg;
            end
            S_RPT_CHK:
            begin
                numer_reg <= tgt_reg - lprod_reg;
                denom_reg <= prod_reg - lprod_reg;
                if (prod_reg < tgt_reg)
                begin
                    if (idx_reg == lhp_pkg::LAST_BUCKET)
                        r_reg <= max_fx;    // threshold never reached: no clamp
                    else
                        idx_reg <= idx_reg + lhp_pkg::BIDX_W'(1);
                end
            end
            S_RPT_HIT:
            begin
                if ((denom_reg != '0) && (numer_reg != '0) &&
                    (idx_reg == lhp_pkg::LAST_BUCKET))
                    r_reg <= max_fx;    // open-ended last bucket
                else
                    r_reg <= lhp_pkg::VALUE_W'(left_lim) << 8;
            end
            S_RPT_DIV:
                if (md_done)
                    r_reg <= r_reg + lhp_pkg::VALUE_W'(md_quot);
            S_CLAMP:
                r_reg <= (r_lo > max_fx) ? max_fx : r_lo;
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_reg.percentile_value <= empty_reg ? '0 : r_reg;
                    rsp_reg.min_seen         <= min_reg;
                    rsp_reg.max_seen         <= max_reg;
                    rsp_reg.sample_count     <= total_reg;
                    rsp_reg.empty_res        <= empty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.empty_res |-> rsp.percentile_value == '0)
        else $error("empty report with nonzero percentile");

    a_nonempty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.empty_res |-> rsp.sample_count != '0)
        else $error("non-empty report with zero count");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.empty_res |->
            (rsp.percentile_value <= {rsp.max_seen, 8'b0}) &&
            (rsp.percentile_value >= {rsp.min_seen, 8'b0}))
        else $error("percentile outside min/max");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> $past(st_rd_en) && !st_rd_en)
        else $error("bucket write without preceding read");

endmodule

`default_nettype wire
